FILE: sv/xshl_pkg.sv
// Shared types and constants for the XML highlight lexer.
package xshl_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int RS_SLOTS    = 3;

    typedef enum logic [3:0] {
        M_TEXT      = 4'd0,
        M_ELEM      = 4'd1,
        M_ATTR_NAME = 4'd2,
        M_ATTR_VAL  = 4'd3,
        M_SQUOTE    = 4'd4,
        M_DQUOTE    = 4'd5,
        M_COMMENT   = 4'd6,
        M_NUM_IN    = 4'd7,
        M_NUM_ZERO  = 4'd8,
        M_NUM_HEX   = 4'd9,
        M_NUM_FRAC  = 4'd10,
        M_NUM_SIGN  = 4'd11,
        M_NUM_EXP   = 4'd12
    } lex_mode_t;

    typedef enum logic [2:0] {
        ST_NONE     = 3'd0,
        ST_DEFINE   = 3'd1,
        ST_COMMENT  = 3'd2,
        ST_CONTROL  = 3'd3,
        ST_VARTYPE  = 3'd4,
        ST_CONST    = 3'd5,
        ST_NONASCII = 3'd6
    } style_t;

    // One lexed byte: restyles of earlier bytes, then the style of the byte itself.
    typedef struct packed {
        logic [1:0]                   rs_count;
        logic [RS_SLOTS-1:0][1:0]     rs_back;
        logic [RS_SLOTS-1:0][2:0]     rs_style;
        style_t                       cur_style;
    } pkt_t;

endpackage

FILE: sv/xshl_front.sv
// Front end: lexer state, per-byte classification into a result packet.
module xshl_front
    import xshl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] char_code,
    input  logic       line_start,
    input  logic       last_in_line,
    output pkt_t       pkt
);

    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_QUES  = 8'h3F;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_E_LO  = 8'h65;
    localparam logic [7:0] CH_E_UP  = 8'h45;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SQ    = 8'h27;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam int         MAX_PASSES = 8;

    typedef struct packed {
        lex_mode_t                mode;
        logic                     name_seen;
        logic [1:0]               phase;
        logic                     esc;
        logic [1:0]               n;
        logic [RS_SLOTS-1:0][1:0] rb;
        logic [RS_SLOTS-1:0][2:0] rst;
        style_t                   cur;
        logic                     redo;
    } work_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_xdigit(input logic [7:0] c);
        return is_digit(c) || ((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46));
    endfunction

    function automatic logic is_ident(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || (c == CH_UNDER);
    endfunction

    function automatic logic is_xml_ident(input logic [7:0] c);
        return is_ident(c) || (c == CH_DASH) || (c == CH_DOT) || (c == CH_COLON);
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SP) || (c == CH_TAB);
    endfunction

    function automatic work_t put_rs(input work_t wi, input logic [1:0] b, input style_t st);
        work_t w;
        w = wi;
        if (w.n < 2'd3)
        begin
            w.rb[w.n]  = b;
            w.rst[w.n] = st;
            w.n        = w.n + 2'd1;
        end
        return w;
    endfunction

    // One pass of the mode machine; sets redo when the byte is not consumed.
    function automatic work_t lex_pass(input work_t wi, input logic [7:0] c,
                                       input logic [7:0] c1, input logic [7:0] c2,
                                       input logic [7:0] c3, input logic lst);
        work_t     w;
        logic [7:0] qch;
        w      = wi;
        w.redo = 1'b0;
        qch    = (w.mode == M_SQUOTE) ? CH_SQ : CH_DQ;
        unique case (w.mode)
            M_ELEM:
            begin
                if (c == CH_GT)
                begin
                    w.cur  = ST_DEFINE;
                    w.mode = M_TEXT;
                end
                else if (c == CH_SLASH || c == CH_QUES)
                    w.cur = ST_DEFINE;
                else if (!w.name_seen)
                begin
                    if (is_xml_ident(c))
                    begin
                        w.name_seen = 1'b1;
                        w.cur       = ST_CONTROL;
                    end
                    else if (is_blank(c))
                        w.cur = ST_DEFINE;
                    else
                        w.cur = ST_NONASCII;
                end
                else
                begin
                    if (is_xml_ident(c))
                        w.cur = ST_CONTROL;
                    else if (is_blank(c))
                    begin
                        w.cur   = ST_CONTROL;
                        w.mode  = M_ATTR_NAME;
                        w.phase = 2'd0;
                    end
                    else
                        w.cur = ST_NONASCII;
                end
            end
            M_ATTR_NAME:
            begin
                if (c == CH_GT)
                begin
                    w.cur  = ST_DEFINE;
                    w.mode = M_TEXT;
                end
                else if (c == CH_SLASH || c == CH_QUES)
                    w.cur = ST_DEFINE;
                else if (w.phase == 2'd0)
                begin
                    if (is_xml_ident(c))
                    begin
                        w.phase = 2'd1;
                        w.cur   = ST_VARTYPE;
                    end
                    else if (is_blank(c))
                        w.cur = ST_CONTROL;
                    else
                        w.cur = ST_NONASCII;
                end
                else if (w.phase == 2'd1)
                begin
                    if (is_xml_ident(c))
                        w.cur = ST_VARTYPE;
                    else if (is_blank(c))
                    begin
                        w.phase = 2'd2;
                        w.cur   = ST_CONTROL;
                    end
                    else if (c == CH_EQ)
                    begin
                        w.phase = 2'd2;
                        w.cur   = ST_DEFINE;
                        w.mode  = M_ATTR_VAL;
                    end
                    else
                        w.cur = ST_NONASCII;
                end
                else
                begin
                    if (c == CH_EQ)
                    begin
                        w.cur  = ST_DEFINE;
                        w.mode = M_ATTR_VAL;
                    end
                    else if (is_blank(c))
                        w.cur = ST_VARTYPE;
                    else
                        w.cur = ST_NONASCII;
                end
            end
            M_ATTR_VAL:
            begin
                if (c == CH_GT)
                begin
                    w.cur  = ST_DEFINE;
                    w.mode = M_TEXT;
                end
                else if (c == CH_SLASH || c == CH_QUES)
                    w.cur = ST_DEFINE;
                else if (c == CH_SQ)
                begin
                    w.cur  = ST_CONST;
                    w.mode = M_SQUOTE;
                    w.esc  = 1'b0;
                end
                else if (c == CH_DQ)
                begin
                    w.cur  = ST_CONST;
                    w.mode = M_DQUOTE;
                    w.esc  = 1'b0;
                end
                else if (is_blank(c))
                    w.cur = ST_DEFINE;
                else
                    w.cur = ST_NONASCII;
            end
            M_SQUOTE, M_DQUOTE:
            begin
                w.cur = ST_CONST;
                if (c == qch && (c1 != CH_BSL || w.esc))
                begin
                    w.mode  = M_ATTR_NAME;
                    w.phase = 2'd0;
                end
                else if (c1 == CH_BSL && c == CH_BSL)
                    w.esc = ~w.esc;
                else
                    w.esc = 1'b0;
            end
            M_COMMENT:
            begin
                if (c2 == CH_DASH && c1 == CH_DASH && c == CH_GT)
                begin
                    w      = put_rs(w, 2'd2, ST_COMMENT);
                    w      = put_rs(w, 2'd1, ST_COMMENT);
                    w.mode = M_TEXT;
                end
                w.cur = ST_COMMENT;
            end
            M_NUM_ZERO:
            begin
                if (c == CH_X && !lst)
                begin
                    w.cur  = ST_CONST;
                    w.mode = M_NUM_HEX;
                end
                else
                begin
                    w.mode = M_NUM_IN;
                    w.redo = 1'b1;
                end
            end
            M_NUM_IN:
            begin
                if (c == CH_DOT)
                begin
                    w.cur  = ST_CONST;
                    w.mode = M_NUM_FRAC;
                end
                else if (c == CH_E_LO || c == CH_E_UP)
                begin
                    w.cur  = ST_CONST;
                    w.mode = M_NUM_SIGN;
                end
                else if (is_digit(c))
                    w.cur = ST_CONST;
                else
                begin
                    w.mode = M_TEXT;
                    w.redo = 1'b1;
                end
            end
            M_NUM_HEX:
            begin
                if (is_xdigit(c))
                    w.cur = ST_CONST;
                else
                begin
                    w.mode = M_TEXT;
                    w.redo = 1'b1;
                end
            end
            M_NUM_FRAC:
            begin
                if (is_digit(c))
                    w.cur = ST_CONST;
                else if (c == CH_E_LO || c == CH_E_UP)
                begin
                    w.cur  = ST_CONST;
                    w.mode = M_NUM_SIGN;
                end
                else
                begin
                    w.mode = M_TEXT;
                    w.redo = 1'b1;
                end
            end
            M_NUM_SIGN:
            begin
                w.mode = M_NUM_EXP;
                if (c == CH_PLUS || c == CH_DASH)
                    w.cur = ST_CONST;
                else
                    w.redo = 1'b1;
            end
            M_NUM_EXP:
            begin
                if (is_digit(c))
                    w.cur = ST_CONST;
                else
                begin
                    w.mode = M_TEXT;
                    w.redo = 1'b1;
                end
            end
            default:
            begin
                w.mode = M_TEXT;
                w.cur  = ST_NONE;
                if (c1 == CH_LT && c != CH_BANG && c != CH_SLASH)
                begin
                    w           = put_rs(w, 2'd1, ST_DEFINE);
                    w.mode      = M_ELEM;
                    w.name_seen = 1'b0;
                    w.redo      = 1'b1;
                end
                else if (c1 == CH_LT && c == CH_SLASH)
                begin
                    w           = put_rs(w, 2'd1, ST_DEFINE);
                    w.cur       = ST_DEFINE;
                    w.mode      = M_ELEM;
                    w.name_seen = 1'b0;
                end
                else if (c3 == CH_LT && c2 == CH_BANG && c1 == CH_DASH && c == CH_DASH)
                begin
                    w      = put_rs(w, 2'd3, ST_COMMENT);
                    w      = put_rs(w, 2'd2, ST_COMMENT);
                    w      = put_rs(w, 2'd1, ST_COMMENT);
                    w.cur  = ST_COMMENT;
                    w.mode = M_COMMENT;
                end
                else if (!is_ident(c1) && is_digit(c))
                begin
                    w.cur  = ST_CONST;
                    w.mode = (c == CH_ZERO) ? M_NUM_ZERO : M_NUM_IN;
                end
            end
        endcase
        return w;
    endfunction

    lex_mode_t  mode_reg, mode_next;
    logic       name_seen_reg, name_seen_next;
    logic [1:0] phase_reg, phase_next;
    logic       esc_reg, esc_next;
    logic [23:0] recent_reg, recent_next;

    logic [23:0] recent_eff;
    work_t       w_start;
    work_t       w_end;

    always_comb
    begin
        recent_eff        = line_start ? 24'd0 : recent_reg;
        w_start           = '0;
        w_start.mode      = mode_reg;
        w_start.name_seen = name_seen_reg;
        w_start.phase     = phase_reg;
        w_start.esc       = line_start ? 1'b0 : esc_reg;
        w_start.cur       = ST_NONE;
        w_start.redo      = 1'b1;
        // a new line ends any number scan
        if (line_start && (mode_reg >= M_NUM_IN) && (mode_reg <= M_NUM_EXP))
            w_start.mode = M_TEXT;
        w_end = w_start;
        for (int i = 0; i < MAX_PASSES; i++)
        begin
            if (w_end.redo)
                w_end = lex_pass(w_end, char_code, recent_eff[7:0], recent_eff[15:8],
                                 recent_eff[23:16], last_in_line);
        end
        mode_next      = w_end.mode;
        name_seen_next = w_end.name_seen;
        phase_next     = w_end.phase;
        esc_next       = w_end.esc;
        recent_next    = {recent_eff[15:0], char_code};

        pkt.rs_count  = w_end.n;
        pkt.rs_back   = w_end.rb;
        pkt.rs_style  = w_end.rst;
        pkt.cur_style = w_end.cur;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= M_TEXT;
            name_seen_reg <= 1'b0;
            phase_reg     <= 2'd0;
            esc_reg       <= 1'b0;
            recent_reg    <= 24'd0;
        end
        else if (accept)
        begin
            mode_reg      <= mode_next;
            name_seen_reg <= name_seen_next;
            phase_reg     <= phase_next;
            esc_reg       <= esc_next;
            recent_reg    <= recent_next;
        end
    end

endmodule

FILE: sv/xshl_queue.sv
// Small packet FIFO between the lexer front end and the result serializer.
module xshl_queue
    import xshl_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  pkt_t wr_data,
    input  logic rd_en,
    output pkt_t rd_data,
    output logic full,
    output logic empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    pkt_t             slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == FULL_CNT);
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            slots_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

FILE: sv/xshl_back.sv
// Back end: serializes one packet into result beats, restyles first.
module xshl_back
    import xshl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  pkt_t       q_data,
    input  logic       q_empty,
    output logic       q_pop,
    input  logic       pop,
    output logic       empty,
    output logic [1:0] back_offset,
    output logic [2:0] style_class,
    output logic       last_result
);

    pkt_t       pkt_reg;
    logic       valid_reg, valid_next;
    logic [1:0] idx_reg, idx_next;
    logic       is_last;
    logic       take;

    assign is_last = (idx_reg >= pkt_reg.rs_count);
    assign empty   = !valid_reg;
    // reload in the same cycle the final beat leaves, so packets run back to back
    assign take    = !valid_reg || (pop && is_last);
    assign q_pop   = take && !q_empty;

    always_comb
    begin
        if (is_last)
        begin
            back_offset = 2'd0;
            style_class = pkt_reg.cur_style;
            last_result = 1'b1;
        end
        else
        begin
            back_offset = pkt_reg.rs_back[idx_reg];
            style_class = pkt_reg.rs_style[idx_reg];
            last_result = 1'b0;
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (take)
        begin
            valid_next = !q_empty;
            idx_next   = 2'd0;
        end
        else if (pop)
            idx_next = idx_reg + 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            pkt_reg <= q_data;
    end

endmodule

FILE: sv/xml_syntax_highlight_lexer_core.sv
// Top level of the XML syntax highlight lexer.
// The block takes one text byte per beat and gives 1 to 4 result beats for it:
// restyles of up to three earlier bytes (largest offset first), then the style
// of the byte itself with last_result set. The front end lexes a byte in the
// cycle it is pushed, so bytes are taken at one per cycle while the packet
// queue (QUEUE_DEPTH packets) has room; full rises only when it fills. The
// back end drains one result beat per cycle while pop is held, so a byte with
// k results holds it for k pops and the queue absorbs the rare multi-result
// bytes. A result reaches the output ports through the queue slot and then
// the back end packet register.
module xml_syntax_highlight_lexer_core
    import xshl_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] char_code,
    input  logic       line_start,
    input  logic       last_in_line,
    input  logic       pop,
    output logic       empty,
    output logic [1:0] back_offset,
    output logic [2:0] style_class,
    output logic       last_result
);

    pkt_t front_pkt;
    pkt_t q_data;
    logic q_empty;
    logic q_pop;
    logic accept;

    assign accept = push && !full;

    xshl_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .char_code    (char_code),
        .line_start   (line_start),
        .last_in_line (last_in_line),
        .pkt          (front_pkt)
    );

    xshl_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept),
        .wr_data (front_pkt),
        .rd_en   (q_pop),
        .rd_data (q_data),
        .full    (full),
        .empty   (q_empty)
    );

    xshl_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_data      (q_data),
        .q_empty     (q_empty),
        .q_pop       (q_pop),
        .pop         (pop),
        .empty       (empty),
        .back_offset (back_offset),
        .style_class (style_class),
        .last_result (last_result)
    );

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for the XML syntax highlight lexer core.
`timescale 1ns / 1ps

module testbench
    import xshl_pkg::*;
();

    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 16;

    localparam logic [7:0] CH_LT    = "<";
    localparam logic [7:0] CH_GT    = ">";
    localparam logic [7:0] CH_BANG  = "!";
    localparam logic [7:0] CH_SLASH = "/";
    localparam logic [7:0] CH_DASH  = "-";
    localparam logic [7:0] CH_QUEST = "?";
    localparam logic [7:0] CH_EQ    = "=";
    localparam logic [7:0] CH_X     = "x";
    localparam logic [7:0] CH_DOT   = ".";
    localparam logic [7:0] CH_LC_E  = "e";
    localparam logic [7:0] CH_UC_E  = "E";
    localparam logic [7:0] CH_BSL   = "\\";
    localparam logic [7:0] CH_SQ    = "'";
    localparam logic [7:0] CH_DQ    = "\"";
    localparam logic [7:0] CH_ZERO  = "0";
    localparam logic [7:0] CH_PLUS  = "+";
    localparam logic [7:0] CH_SPACE = " ";
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_UNDER = "_";
    localparam logic [7:0] CH_COLON = ":";

    typedef struct {
        logic [1:0] back;
        style_t     style;
        logic       tail;
    } hl_beat_t;

    class lex_scoreboard;
        lex_mode_t   mode;
        bit          name_seen;
        logic [1:0]  attr_phase;
        bit          esc;
        logic [23:0] recent;
        int          n_rs;
        int          errors;
        hl_beat_t    styles_due[$];

        function new();
            mode       = M_TEXT;
            name_seen  = 0;
            attr_phase = '0;
            esc        = 0;
            recent     = '0;
            errors     = 0;
        endfunction

        function bit digit(logic [7:0] c);
            return c >= "0" && c <= "9";
        endfunction

        function bit alpha(logic [7:0] c);
            return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
        endfunction

        function bit xdigit(logic [7:0] c);
            return digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
        endfunction

        function bit ident(logic [7:0] c);
            return alpha(c) || digit(c) || c == CH_UNDER;
        endfunction

        function bit xml_ident(logic [7:0] c);
            return ident(c) || c == CH_DASH || c == CH_DOT || c == CH_COLON;
        endfunction

        function bit blank(logic [7:0] c);
            return c == CH_SPACE || c == CH_TAB;
        endfunction

        function void restyle(logic [1:0] back, style_t style);
            hl_beat_t b;
            if (n_rs < RS_SLOTS) begin
                b.back  = back;
                b.style = style;
                b.tail  = 1'b0;
                styles_due.push_back(b);
                n_rs++;
            end
        endfunction

        function int pending();
            return styles_due.size();
        endfunction

        // Lex one accepted byte and queue the beats it should produce.
        function void note_byte(logic [7:0] c, logic ls, logic eol);
            logic [7:0] c1, c2, c3;
            style_t     cur;
            bit         redo;
            hl_beat_t   b;
            cur  = ST_NONE;
            redo = 1;
            n_rs = 0;
            if (ls) begin
                recent = '0;
                esc    = 0;
                if (mode >= M_NUM_IN) mode = M_TEXT;
            end
            c1 = recent[7:0];
            c2 = recent[15:8];
            c3 = recent[23:16];
            for (int i = 0; i < 8 && redo; i++) begin
                redo = 0;
                case (mode)
                    M_ELEM:
                    begin
                        if (c == CH_GT) begin cur = ST_DEFINE; mode = M_TEXT; end
                        else if (c == CH_SLASH || c == CH_QUEST) cur = ST_DEFINE;
                        else if (!name_seen) begin
                            if (xml_ident(c)) begin name_seen = 1; cur = ST_CONTROL; end
                            else if (blank(c)) cur = ST_DEFINE;
                            else cur = ST_NONASCII;
                        end
                        else begin
                            if (xml_ident(c)) cur = ST_CONTROL;
                            else if (blank(c))
                            begin
                                cur = ST_CONTROL;
                                mode = M_ATTR_NAME;
                                attr_phase = 2'd0;
                            end
                            else cur = ST_NONASCII;
                        end
                    end
                    M_ATTR_NAME:
                    begin
                        if (c == CH_GT) begin cur = ST_DEFINE; mode = M_TEXT; end
                        else if (c == CH_SLASH || c == CH_QUEST) cur = ST_DEFINE;
                        else if (attr_phase == 2'd0) begin
                            if (xml_ident(c)) begin attr_phase = 2'd1; cur = ST_VARTYPE; end
                            else if (blank(c)) cur = ST_CONTROL;
                            else cur = ST_NONASCII;
                        end
                        else if (attr_phase == 2'd1) begin
                            if (xml_ident(c)) cur = ST_VARTYPE;
                            else if (blank(c)) begin attr_phase = 2'd2; cur = ST_CONTROL; end
                            else if (c == CH_EQ)
                            begin
                                attr_phase = 2'd2;
                                cur = ST_DEFINE;
                                mode = M_ATTR_VAL;
                            end
                            else cur = ST_NONASCII;
                        end
                        else begin
                            // phase three acts like phase two
                            if (c == CH_EQ) begin cur = ST_DEFINE; mode = M_ATTR_VAL; end
                            else if (blank(c)) cur = ST_VARTYPE;
                            else cur = ST_NONASCII;
                        end
                    end
                    M_ATTR_VAL:
                    begin
                        if (c == CH_GT) begin cur = ST_DEFINE; mode = M_TEXT; end
                        else if (c == CH_SLASH || c == CH_QUEST) cur = ST_DEFINE;
                        else if (c == CH_SQ) begin cur = ST_CONST; mode = M_SQUOTE; esc = 0; end
                        else if (c == CH_DQ) begin cur = ST_CONST; mode = M_DQUOTE; esc = 0; end
                        else if (blank(c)) cur = ST_DEFINE;
                        else cur = ST_NONASCII;
                    end
                    M_SQUOTE, M_DQUOTE:
                    begin
                        cur = ST_CONST;
                        if (c == ((mode == M_SQUOTE) ? CH_SQ : CH_DQ) && (c1 != CH_BSL || esc))
                        begin
                            mode = M_ATTR_NAME;
                            attr_phase = 2'd0;
                        end
                        else if (c1 == CH_BSL && c == CH_BSL) esc = !esc;
                        else esc = 0;
                    end
                    M_COMMENT:
                    begin
                        if (c2 == CH_DASH && c1 == CH_DASH && c == CH_GT) begin
                            restyle(2'd2, ST_COMMENT);
                            restyle(2'd1, ST_COMMENT);
                            mode = M_TEXT;
                        end
                        cur = ST_COMMENT;
                    end
                    M_NUM_ZERO:
                    begin
                        if (c == CH_X && !eol) begin cur = ST_CONST; mode = M_NUM_HEX; end
                        else begin mode = M_NUM_IN; redo = 1; end
                    end
                    M_NUM_IN:
                    begin
                        if (c == CH_DOT) begin cur = ST_CONST; mode = M_NUM_FRAC; end
                        else if (c == CH_LC_E || c == CH_UC_E) begin cur = ST_CONST; mode = M_NUM_SIGN; end
                        else if (digit(c)) cur = ST_CONST;
                        else begin mode = M_TEXT; redo = 1; end
                    end
                    M_NUM_HEX:
                    begin
                        if (xdigit(c)) cur = ST_CONST;
                        else begin mode = M_TEXT; redo = 1; end
                    end
                    M_NUM_FRAC:
                    begin
                        if (digit(c)) cur = ST_CONST;
                        else if (c == CH_LC_E || c == CH_UC_E) begin cur = ST_CONST; mode = M_NUM_SIGN; end
                        else begin mode = M_TEXT; redo = 1; end
                    end
                    M_NUM_SIGN:
                    begin
                        if (c == CH_PLUS || c == CH_DASH) begin cur = ST_CONST; mode = M_NUM_EXP; end
                        else begin mode = M_NUM_EXP; redo = 1; end
                    end
                    M_NUM_EXP:
                    begin
                        if (digit(c)) cur = ST_CONST;
                        else begin mode = M_TEXT; redo = 1; end
                    end
                    default:
                    begin
                        mode = M_TEXT;
                        cur  = ST_NONE;
                        if (c1 == CH_LT && c != CH_BANG && c != CH_SLASH) begin
                            // tag opener: relex this byte as the element name
                            restyle(2'd1, ST_DEFINE);
                            mode = M_ELEM;
                            name_seen = 0;
                            redo = 1;
                        end
                        else if (c1 == CH_LT && c == CH_SLASH) begin
                            restyle(2'd1, ST_DEFINE);
                            cur = ST_DEFINE;
                            mode = M_ELEM;
                            name_seen = 0;
                        end
                        else if (c3 == CH_LT && c2 == CH_BANG && c1 == CH_DASH && c == CH_DASH)
                        begin
                            restyle(2'd3, ST_COMMENT);
                            restyle(2'd2, ST_COMMENT);
                            restyle(2'd1, ST_COMMENT);
                            cur = ST_COMMENT;
                            mode = M_COMMENT;
                        end
                        else if (!ident(c1) && digit(c)) begin
                            cur = ST_CONST;
                            mode = (c == CH_ZERO) ? M_NUM_ZERO : M_NUM_IN;
                        end
                    end
                endcase
            end
            b.back  = 2'd0;
            b.style = cur;
            b.tail  = 1'b1;
            styles_due.push_back(b);
            recent = {recent[15:0], c};
        endfunction

        function void check_beat(logic [1:0] back, logic [2:0] style, logic tail);
            hl_beat_t want;
            if (styles_due.size() == 0) begin
                $error("result with nothing pending: back_offset=%0d style_class=%0d last_result=%0d",
                       back, style, tail);
                errors++;
                return;
            end
            want = styles_due.pop_front();
            if (back !== want.back) begin
                $error("back_offset: expected %0d, got %0d", want.back, back);
                errors++;
            end
            if (style !== want.style) begin
                $error("style_class: expected %0d, got %0d", want.style, style);
                errors++;
            end
            if (tail !== want.tail) begin
                $error("last_result: expected %0d, got %0d", want.tail, tail);
                errors++;
            end
        endfunction
    endclass

    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       push         = 1'b0;
    logic       full;
    logic [7:0] char_code    = '0;
    logic       line_start   = 1'b0;
    logic       last_in_line = 1'b0;
    logic       pop          = 1'b0;
    logic       empty;
    logic [1:0] back_offset;
    logic [2:0] style_class;
    logic       last_result;

    lex_scoreboard board;
    int          send_idle;
    int          recv_stall;
    int          stall_left;
    int          sent;
    int          cycles;
    logic [7:0]  line_q[$];

    xml_syntax_highlight_lexer_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .char_code    (char_code),
        .line_start   (line_start),
        .last_in_line (last_in_line),
        .pop          (pop),
        .empty        (empty),
        .back_offset  (back_offset),
        .style_class  (style_class),
        .last_result  (last_result)
    );

    always #10 clk = ~clk;

    // Result side: check every popped beat, stall at random or for a requested stretch.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (pop && !empty) board.check_beat(back_offset, style_class, last_result);
            if (stall_left > 0) begin
                stall_left--;
                pop <= 1'b0;
            end
            else pop <= ($urandom_range(99) >= recv_stall);
        end
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT) @(posedge clk) cycles++;
        $display("testbench: done, errors");
        $finish;
    end

    task automatic send_byte(input logic [7:0] c, input logic ls, input logic eol);
        if ($urandom_range(99) < send_idle) begin
            push <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle);
        end
        push         <= 1'b1;
        char_code    <= c;
        line_start   <= ls;
        last_in_line <= eol;
        do @(posedge clk); while (full);
        board.note_byte(c, ls, eol);
        sent++;
    endtask

    // Send the assembled line; the line marks are flipped now and then.
    task automatic send_line();
        logic ls, eol;
        for (int i = 0; i < line_q.size(); i++) begin
            ls  = (i == 0);
            eol = (i == line_q.size() - 1);
            if ($urandom_range(99) < 3) ls = !ls;
            if ($urandom_range(99) < 3) eol = !eol;
            send_byte(line_q[i], ls, eol);
        end
        line_q.delete();
    endtask

    task automatic drain();
        push <= 1'b0;
        do @(posedge clk); while (board.pending() != 0);
    endtask

    function automatic void add_str(string s);
        for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
    endfunction

    function automatic void add_pick(string s, int count);
        for (int i = 0; i < count; i++) line_q.push_back(s[$urandom_range(0, s.len() - 1)]);
    endfunction

    function automatic void add_quoted();
        logic [7:0] q;
        int         len;
        q   = $urandom_range(1) ? CH_DQ : CH_SQ;
        len = $urandom_range(0, 5);
        line_q.push_back(q);
        for (int i = 0; i < len; i++) begin
            case ($urandom_range(0, 7))
                0, 1:    line_q.push_back(CH_BSL);
                2:       line_q.push_back(CH_SQ);
                3:       line_q.push_back(CH_DQ);
                7:       line_q.push_back(8'($urandom_range(0, 255)));
                default: add_pick("aZ9 >/", 1);
            endcase
        end
        line_q.push_back(q);
    endfunction

    function automatic void add_tag();
        int n_attr;
        if ($urandom_range(0, 4) == 0)
            add_str("<?");
        else
            add_str("<");
        add_pick("azAZ09_-.:mQ", $urandom_range(1, 4));
        n_attr = $urandom_range(0, 2);
        for (int i = 0; i < n_attr; i++) begin
            add_pick(" \t ", $urandom_range(1, 2));
            add_pick("azAZ09_-.:kR", $urandom_range(1, 4));
            if ($urandom_range(0, 3) == 0) add_str(" ");
            add_str("=");
            if ($urandom_range(0, 3) == 0) add_str(" ");
            add_quoted();
        end
        if ($urandom_range(0, 3) == 0) add_str($urandom_range(1) ? "/" : "?");
        add_str(">");
    endfunction

    function automatic void add_number();
        add_str(" ");
        case ($urandom_range(0, 3))
            0: add_pick("0123456789", $urandom_range(1, 4));
            1:
            begin
                add_str("0x");
                add_pick("09afAFgx", $urandom_range(0, 4));
            end
            2:
            begin
                add_pick("0123456789", $urandom_range(1, 3));
                add_str(".");
                add_pick("0123456789eE", $urandom_range(0, 3));
            end
            default:
            begin
                add_pick("0123456789", $urandom_range(1, 3));
                add_pick("eE", 1);
                if ($urandom_range(1)) add_pick("+-", 1);
                add_pick("0123456789x", $urandom_range(0, 3));
            end
        endcase
    endfunction

    function automatic void add_fragment();
        case ($urandom_range(0, 9))
            0, 1, 2: add_tag();
            3:
            begin
                add_str("</");
                add_pick("azAZ09-.:", $urandom_range(1, 4));
                add_str(">");
            end
            4:
            begin
                add_str("<!--");
                add_pick("-> a!<", $urandom_range(0, 5));
                add_str("-->");
            end
            5, 6: add_number();
            7: add_pick("ab Z_9 <!-", $urandom_range(1, 6));
            default:
                for (int i = $urandom_range(1, 4); i > 0; i--)
                    line_q.push_back(8'($urandom_range(0, 255)));
        endcase
    endfunction

    // Mostly well-formed lines; some are cut short so that modes carry across lines.
    function automatic void build_line();
        int n_frag, keep;
        n_frag = $urandom_range(1, 3);
        for (int i = 0; i < n_frag; i++) add_fragment();
        if ($urandom_range(99) < 15) begin
            keep = $urandom_range(1, line_q.size());
            while (line_q.size() > keep) void'(line_q.pop_back());
        end
    endfunction

    task automatic run_phase(input int sidle, input int rstall, input int count);
        int goal;
        send_idle  = sidle;
        recv_stall = rstall;
        goal       = sent + count;
        while (sent < goal) begin
            build_line();
            send_line();
        end
        drain();
    endtask

    initial
    begin
        int goal;
        board      = new();
        send_idle  = 0;
        recv_stall = 0;
        stall_left = 0;
        sent       = 0;
        cycles     = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // comment opener and closer
        add_str("<!---->");
        send_line();
        // tag with attribute, escaped quote inside the value
        add_str("<p q=\"\\\"\">");
        send_line();
        // '0x' with the x last on its line: no hex prefix
        add_str("0x");
        send_line();
        // fraction and exponent; next line start ends the scan
        add_str("1.E-9");
        send_line();
        line_q.push_back(8'hFF);
        line_q.push_back(8'h00);
        send_line();
        drain();

        run_phase(0, 0, 60);
        run_phase(79, 0, 60);
        run_phase(0, 79, 60);
        run_phase(24, 24, 60);

        // long receiver hold while bytes keep coming: the queue fills and full rises
        send_idle  = 0;
        recv_stall = 0;
        stall_left = 300;
        goal       = sent + 24;
        while (sent < goal) begin
            build_line();
            send_line();
        end
        drain();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (board.errors == 0 && board.pending() == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

FILE: files.f
sv/xshl_pkg.sv
sv/xshl_front.sv
sv/xshl_queue.sv
sv/xshl_back.sv
sv/xml_syntax_highlight_lexer_core.sv
dv/testbench.sv
